FILE: rtl/ucfr_pkg.sv
package ucfr_pkg;

   localparam int unsigned SIGN_LEN = 4;

   localparam logic [1:0] MODE_BYTE    = 2'd0;
   localparam logic [1:0] MODE_TICK    = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [1:0] STATUS_LENGTH   = 2'd2;

   localparam logic [1:0] CSR_START_BYTE    = 2'd0;
   localparam logic [1:0] CSR_END_BYTE      = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [7:0] START_BYTE_RESET    = 8'd92;
   localparam logic [7:0] END_BYTE_RESET      = 8'd202;
   localparam logic [7:0] TIMEOUT_TICKS_RESET = 8'd5;

   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TYPE,
      PH_SIGN,
      PH_LEN,
      PH_DATA,
      PH_XOR,
      PH_END,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_READ,
      EM_LOAD,
      EM_STATUS
   } emit_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
      logic       tx_busy;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  frame_status;
      logic [7:0]  frame_type;
      logic [31:0] frame_sign;
      logic [7:0]  frame_length;
      logic        last_item;
   } rsp_type;

endpackage

FILE: rtl/ucfr_ram.sv
module ucfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/uart_command_frame_receiver_unit.sv
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_stall  | ucfr_pkg::req_type (mode, rx_byte, tx_busy)
// rsp     | out | rsp_valid/rsp_stall  | ucfr_pkg::rsp_type (payload byte or status)
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// A request is taken when no frame is being emitted.
// A good frame of L bytes is read back from the payload RAM byte by byte, then a status
// item follows; rsp_stall holds the output register and slows the emission.
// Requests stall during that emission; each byte needs a RAM read and an output load.
// Reset is synchronous; the payload RAM is not cleared, only written entries are read.
module uart_command_frame_receiver_unit #(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ucfr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ucfr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0]  MAX_LEN = 8'(MAX_PAYLOAD);

   logic [7:0] start_byte_ff, end_byte_ff, timeout_ticks_ff;

   ucfr_pkg::phase_type phase_ff, phase_in;
   ucfr_pkg::emit_type  emit_ff, emit_in;
   logic [2:0]    sign_count_ff, sign_count_in;
   logic [CW-1:0] data_count_ff, data_count_in;
   logic [7:0]    length_ff, length_in;
   logic [7:0]    type_ff, type_in;
   logic [31:0]   sign_ff, sign_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    check_ff, check_in;
   logic          held_ff, held_in;
   logic          receiving_ff, receiving_in;
   logic [7:0]    idle_ff, idle_in;
   logic [1:0]    status_ff, status_in;
   logic [CW-1:0] emit_idx_ff, emit_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ucfr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          req_fire, out_free, do_start, start_hit, do_clear;
   logic [7:0]    idle_next;
   logic [CW-1:0] data_count_inc;
   logic          ram_wr_en, ram_rd_en;
   logic [7:0]    ram_rd_data;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (emit_ff != ucfr_pkg::EM_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign start_hit = (req_data.rx_byte == start_byte_ff);
   assign idle_next = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;
   assign data_count_inc = data_count_ff + CW'(1);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ram_wr_en = req_fire && (req_data.mode == ucfr_pkg::MODE_BYTE)
                      && (phase_ff == ucfr_pkg::PH_DATA)
                      && (data_count_ff < CW'(MAX_PAYLOAD));
   assign ram_rd_en = (emit_ff == ucfr_pkg::EM_READ);

   ucfr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (data_count_ff[AW-1:0]),
      .wr_data (req_data.rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (emit_idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      phase_in      = phase_ff;
      emit_in       = emit_ff;
      sign_count_in = sign_count_ff;
      data_count_in = data_count_ff;
      length_in     = length_ff;
      type_in       = type_ff;
      sign_in       = sign_ff;
      xor_in        = xor_ff;
      check_in      = check_ff;
      held_in       = held_ff;
      receiving_in  = receiving_ff;
      idle_in       = idle_ff;
      status_in     = status_ff;
      emit_idx_in   = emit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      do_start      = 1'b0;
      do_clear      = 1'b0;

      if (req_fire) begin
         unique case (req_data.mode)
            ucfr_pkg::MODE_TICK: begin
               if (receiving_ff) begin
                  idle_in = idle_next;
                  if (idle_next > timeout_ticks_ff) begin
                     phase_in     = ucfr_pkg::PH_HUNT;
                     receiving_in = 1'b0;
                     idle_in      = 8'd0;
                     do_clear     = 1'b1;
                  end
               end
            end
            ucfr_pkg::MODE_RELEASE: begin
               held_in = 1'b0;
            end
            ucfr_pkg::MODE_BYTE: begin
               unique case (phase_ff)
                  ucfr_pkg::PH_DONE: begin
                     do_start = !held_ff && !req_data.tx_busy && start_hit;
                  end
                  ucfr_pkg::PH_HUNT: begin
                     do_start = start_hit;
                  end
                  ucfr_pkg::PH_TYPE: begin
                     type_in  = req_data.rx_byte;
                     xor_in   = xor_ff ^ req_data.rx_byte;
                     idle_in  = 8'd0;
                     phase_in = ucfr_pkg::PH_SIGN;
                  end
                  ucfr_pkg::PH_SIGN: begin
                     sign_in       = {sign_ff[23:0], req_data.rx_byte};
                     xor_in        = xor_ff ^ req_data.rx_byte;
                     idle_in       = 8'd0;
                     sign_count_in = sign_count_ff + 3'd1;
                     if (sign_count_in >= 3'(ucfr_pkg::SIGN_LEN)) begin
                        phase_in = ucfr_pkg::PH_LEN;
                     end
                  end
                  ucfr_pkg::PH_LEN: begin
                     length_in = req_data.rx_byte;
                     xor_in    = xor_ff ^ req_data.rx_byte;
                     idle_in   = 8'd0;
                     priority if (req_data.rx_byte > MAX_LEN) begin
                        status_in    = ucfr_pkg::STATUS_LENGTH;
                        emit_in      = ucfr_pkg::EM_STATUS;
                        phase_in     = ucfr_pkg::PH_HUNT;
                        receiving_in = 1'b0;
                     end else if (req_data.rx_byte != 8'd0) begin
                        phase_in = ucfr_pkg::PH_DATA;
                     end else begin
                        phase_in = ucfr_pkg::PH_XOR;
                     end
                  end
                  ucfr_pkg::PH_DATA: begin
                     data_count_in = data_count_inc;
                     xor_in        = xor_ff ^ req_data.rx_byte;
                     idle_in       = 8'd0;
                     if (8'(data_count_inc) >= length_ff) begin
                        phase_in = ucfr_pkg::PH_XOR;
                     end
                  end
                  ucfr_pkg::PH_XOR: begin
                     check_in = req_data.rx_byte;
                     idle_in  = 8'd0;
                     phase_in = ucfr_pkg::PH_END;
                  end
                  ucfr_pkg::PH_END: begin
                     if (req_data.rx_byte == end_byte_ff) begin
                        if (check_ff != xor_ff) begin
                           status_in = ucfr_pkg::STATUS_CHECKSUM;
                           emit_in   = ucfr_pkg::EM_STATUS;
                        end else begin
                           status_in   = ucfr_pkg::STATUS_GOOD;
                           held_in     = 1'b1;
                           emit_idx_in = '0;
                           emit_in     = (length_ff == 8'd0) ? ucfr_pkg::EM_STATUS
                                                              : ucfr_pkg::EM_READ;
                        end
                        phase_in = ucfr_pkg::PH_DONE;
                     end else begin
                        phase_in = ucfr_pkg::PH_HUNT;
                        do_clear = 1'b1;
                     end
                     receiving_in = 1'b0;
                     idle_in      = 8'd0;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      if (do_start) begin
         do_clear     = 1'b1;
         receiving_in = 1'b1;
         idle_in      = 8'd0;
         phase_in     = ucfr_pkg::PH_TYPE;
      end

      if (do_clear) begin
         sign_count_in = 3'd0;
         data_count_in = '0;
         length_in     = 8'd0;
         type_in       = 8'd0;
         sign_in       = 32'd0;
         xor_in        = 8'd0;
         check_in      = 8'd0;
      end

      unique case (emit_ff)
         ucfr_pkg::EM_READ: begin
            emit_in = ucfr_pkg::EM_LOAD;
         end
         ucfr_pkg::EM_LOAD: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.item_kind    = ucfr_pkg::KIND_PAYLOAD;
               rsp_data_in.payload_byte = ram_rd_data;
               rsp_data_in.frame_status = ucfr_pkg::STATUS_GOOD;
               rsp_data_in.frame_type   = type_ff;
               rsp_data_in.frame_sign   = sign_ff;
               rsp_data_in.frame_length = length_ff;
               rsp_data_in.last_item    = 1'b0;
               emit_idx_in              = emit_idx_ff + CW'(1);
               emit_in = (8'(emit_idx_in) >= length_ff) ? ucfr_pkg::EM_STATUS
                                                        : ucfr_pkg::EM_READ;
            end
         end
         ucfr_pkg::EM_STATUS: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.item_kind    = ucfr_pkg::KIND_STATUS;
               rsp_data_in.payload_byte = 8'd0;
               rsp_data_in.frame_status = status_ff;
               rsp_data_in.frame_type   = type_ff;
               rsp_data_in.frame_sign   = sign_ff;
               rsp_data_in.frame_length = length_ff;
               rsp_data_in.last_item    = 1'b1;
               emit_in                  = ucfr_pkg::EM_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= ucfr_pkg::START_BYTE_RESET;
         end_byte_ff      <= ucfr_pkg::END_BYTE_RESET;
         timeout_ticks_ff <= ucfr_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ucfr_pkg::CSR_START_BYTE:    start_byte_ff    <= csr_wdata;
            ucfr_pkg::CSR_END_BYTE:      end_byte_ff      <= csr_wdata;
            ucfr_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ucfr_pkg::PH_HUNT;
         emit_ff       <= ucfr_pkg::EM_IDLE;
         sign_count_ff <= 3'd0;
         data_count_ff <= '0;
         length_ff     <= 8'd0;
         type_ff       <= 8'd0;
         sign_ff       <= 32'd0;
         xor_ff        <= 8'd0;
         check_ff      <= 8'd0;
         held_ff       <= 1'b0;
         receiving_ff  <= 1'b0;
         idle_ff       <= 8'd0;
         status_ff     <= ucfr_pkg::STATUS_GOOD;
         emit_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         emit_ff       <= emit_in;
         sign_count_ff <= sign_count_in;
         data_count_ff <= data_count_in;
         length_ff     <= length_in;
         type_ff       <= type_in;
         sign_ff       <= sign_in;
         xor_ff        <= xor_in;
         check_ff      <= check_in;
         held_ff       <= held_in;
         receiving_ff  <= receiving_in;
         idle_ff       <= idle_in;
         status_ff     <= status_in;
         emit_idx_ff   <= emit_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/ucfr_checker.sv
module ucfr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ucfr_pkg::rsp_type rsp_data
);

   // output register holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_payload_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.item_kind == ucfr_pkg::KIND_PAYLOAD)
      |-> !rsp_data.last_item && (rsp_data.frame_status == ucfr_pkg::STATUS_GOOD))
      else $error("payload item marked last or with status");

   a_status_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.item_kind == ucfr_pkg::KIND_STATUS)
      |-> rsp_data.last_item && (rsp_data.payload_byte == 8'd0))
      else $error("status item malformed");

   // requests are held off until a frame's emission is complete
   a_emit_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_item |-> req_stall)
      else $error("request taken during payload emission");

endmodule

bind uart_command_frame_receiver_unit ucfr_checker u_ucfr_checker (.*);

FILE: dv/tb_uart_command_frame_receiver_unit.sv
module tb_uart_command_frame_receiver_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD     = 32;
   localparam int DRAIN_CYCLES    = 12;
   localparam int TAIL_CYCLES     = 100;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_REQUESTS = 48;
   localparam int LONG_HOLD       = 300;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   ucfr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   ucfr_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [7:0]        csr_wdata;

   bit sender_idling    = 1'b1;
   bit receiver_idling  = 1'b1;
   int long_hold_cycles = 0;
   int requests_sent    = 0;
   int mismatch_count   = 0;
   int quiet_cycles     = 0;

   // frame decoder shadow state
   logic [7:0]          cfg_start;
   logic [7:0]          cfg_end;
   logic [7:0]          cfg_timeout;
   ucfr_pkg::phase_type rx_phase;
   logic [2:0]          sign_cnt;
   logic [5:0]          data_cnt;
   logic [7:0]          len_q;
   logic [7:0]          type_q;
   logic [31:0]         sign_q;
   logic [7:0]          xor_q;
   logic [7:0]          check_q;
   logic [7:0]          payload_mem [0:MAX_PAYLOAD-1];
   logic                held_q;
   logic                active_q;
   logic [7:0]          idle_q;

   ucfr_pkg::rsp_type expected_items[$];

   uart_command_frame_receiver_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic void clear_frame_regs();
      sign_cnt = '0;
      data_cnt = '0;
      len_q    = '0;
      type_q   = '0;
      sign_q   = '0;
      xor_q    = '0;
      check_q  = '0;
   endfunction

   function automatic void reset_decoder();
      cfg_start   = ucfr_pkg::START_BYTE_RESET;
      cfg_end     = ucfr_pkg::END_BYTE_RESET;
      cfg_timeout = ucfr_pkg::TIMEOUT_TICKS_RESET;
      rx_phase    = ucfr_pkg::PH_HUNT;
      clear_frame_regs();
      held_q      = 1'b0;
      active_q    = 1'b0;
      idle_q      = '0;
   endfunction

   function automatic void open_frame(input logic [7:0] b);
      if (b == cfg_start) begin
         clear_frame_regs();
         active_q = 1'b1;
         idle_q   = '0;
         rx_phase = ucfr_pkg::PH_TYPE;
      end
   endfunction

   function automatic ucfr_pkg::rsp_type frame_item(input logic kind, input logic [7:0] data,
                                                    input logic [1:0] status,
                                                    input logic last);
      ucfr_pkg::rsp_type item;
      item.item_kind    = kind;
      item.payload_byte = data;
      item.frame_status = status;
      item.frame_type   = type_q;
      item.frame_sign   = sign_q;
      item.frame_length = len_q;
      item.last_item    = last;
      return item;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic busy);
      int i;
      case (rx_phase)
         ucfr_pkg::PH_DONE: begin
            if (!held_q && !busy) open_frame(b);
         end
         ucfr_pkg::PH_HUNT: open_frame(b);
         ucfr_pkg::PH_TYPE: begin
            type_q   = b;
            xor_q    = xor_q ^ b;
            idle_q   = '0;
            rx_phase = ucfr_pkg::PH_SIGN;
         end
         ucfr_pkg::PH_SIGN: begin
            sign_q   = {sign_q[23:0], b};
            xor_q    = xor_q ^ b;
            idle_q   = '0;
            sign_cnt = sign_cnt + 3'd1;
            if (sign_cnt >= 3'(ucfr_pkg::SIGN_LEN)) rx_phase = ucfr_pkg::PH_LEN;
         end
         ucfr_pkg::PH_LEN: begin
            len_q  = b;
            xor_q  = xor_q ^ b;
            idle_q = '0;
            if (b > 8'(MAX_PAYLOAD)) begin
               expected_items.push_back(frame_item(ucfr_pkg::KIND_STATUS, 8'h00,
                                                   ucfr_pkg::STATUS_LENGTH, 1'b1));
               rx_phase = ucfr_pkg::PH_HUNT;
               active_q = 1'b0;
            end else if (b != 8'd0) begin
               rx_phase = ucfr_pkg::PH_DATA;
            end else begin
               rx_phase = ucfr_pkg::PH_XOR;
            end
         end
         ucfr_pkg::PH_DATA: begin
            if (data_cnt < 6'(MAX_PAYLOAD)) payload_mem[data_cnt[4:0]] = b;
            data_cnt = data_cnt + 6'd1;
            xor_q    = xor_q ^ b;
            idle_q   = '0;
            if ({2'b00, data_cnt} >= len_q) rx_phase = ucfr_pkg::PH_XOR;
         end
         ucfr_pkg::PH_XOR: begin
            check_q  = b;
            idle_q   = '0;
            rx_phase = ucfr_pkg::PH_END;
         end
         default: begin
            if (b == cfg_end) begin
               if (check_q != xor_q) begin
                  expected_items.push_back(frame_item(ucfr_pkg::KIND_STATUS, 8'h00,
                                                      ucfr_pkg::STATUS_CHECKSUM, 1'b1));
               end else begin
                  for (i = 0; i < len_q && i < MAX_PAYLOAD; i++)
                     expected_items.push_back(
                        frame_item(ucfr_pkg::KIND_PAYLOAD, payload_mem[5'(i)],
                                   ucfr_pkg::STATUS_GOOD, 1'b0));
                  expected_items.push_back(frame_item(ucfr_pkg::KIND_STATUS, 8'h00,
                                                      ucfr_pkg::STATUS_GOOD, 1'b1));
                  held_q = 1'b1;
               end
               rx_phase = ucfr_pkg::PH_DONE;
            end else begin
               rx_phase = ucfr_pkg::PH_HUNT;
               clear_frame_regs();
            end
            active_q = 1'b0;
            idle_q   = '0;
         end
      endcase
   endfunction

   function automatic void decode_request(input ucfr_pkg::req_type r);
      case (r.mode)
         ucfr_pkg::MODE_BYTE: decode_byte(r.rx_byte, r.tx_busy);
         ucfr_pkg::MODE_TICK: begin
            if (active_q) begin
               if (idle_q != 8'hFF) idle_q = idle_q + 8'd1;
               if (idle_q > cfg_timeout) begin
                  rx_phase = ucfr_pkg::PH_HUNT;
                  clear_frame_regs();
                  active_q = 1'b0;
                  idle_q   = '0;
               end
            end
         end
         ucfr_pkg::MODE_RELEASE: held_q = 1'b0;
         default: ;
      endcase
   endfunction

   task automatic send_request(input logic [1:0] mode, input logic [7:0] data,
                               input logic busy);
      ucfr_pkg::req_type r;
      r.mode    = mode;
      r.rx_byte = data;
      r.tx_busy = busy;
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      decode_request(r);
      if (mode != MODE_UNUSED) requests_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_request(ucfr_pkg::MODE_TICK, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
   endtask

   task automatic send_frame(input logic [7:0] ftype, input logic [31:0] fsign,
                             input logic [7:0] flen, input bit bad_check, input bit bad_end,
                             input int gap_ticks, input int fill, input bit start_busy);
      logic [7:0] frame_bytes[$];
      logic [7:0] check_byte;
      logic [7:0] value;
      int i;
      int gap_at;
      frame_bytes.push_back(cfg_start);
      frame_bytes.push_back(ftype);
      frame_bytes.push_back(fsign[31:24]);
      frame_bytes.push_back(fsign[23:16]);
      frame_bytes.push_back(fsign[15:8]);
      frame_bytes.push_back(fsign[7:0]);
      frame_bytes.push_back(flen);
      check_byte = ftype ^ fsign[31:24] ^ fsign[23:16] ^ fsign[15:8] ^ fsign[7:0] ^ flen;
      if (flen <= MAX_PAYLOAD) begin
         for (i = 0; i < flen; i++) begin
            value = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            check_byte = check_byte ^ value;
            frame_bytes.push_back(value);
         end
         frame_bytes.push_back(bad_check ? check_byte ^ 8'($urandom_range(1, 255))
                                         : check_byte);
         frame_bytes.push_back(bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
      end
      gap_at = $urandom_range(1, frame_bytes.size() - 1);
      for (i = 0; i < frame_bytes.size(); i++) begin
         if (i == gap_at) send_ticks(gap_ticks);
         send_request(ucfr_pkg::MODE_BYTE, frame_bytes[i],
                      (i == 0) ? start_busy : 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (expected_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      wait_for_quiet();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         ucfr_pkg::CSR_START_BYTE:    cfg_start   = value;
         ucfr_pkg::CSR_END_BYTE:      cfg_end     = value;
         ucfr_pkg::CSR_TIMEOUT_TICKS: cfg_timeout = value;
         default: ;
      endcase
   endtask

   task automatic test_default_config();
      send_frame(8'h11, 32'hDEADBEEF, 8'd3, 1'b0, 1'b0, 0, -1, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
   endtask

   task automatic test_field_extremes();
      send_frame(8'hFF, 32'hFFFFFFFF, 8'(MAX_PAYLOAD), 1'b0, 1'b0, 0, 255, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'hFF, 1'b1);
      send_frame(8'h00, 32'h00000000, 8'd0, 1'b0, 1'b0, 0, 0, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
      send_frame(8'h00, 32'h00000000, 8'd1, 1'b0, 1'b0, 0, 0, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
      // oversize lengths, just above the limit and the top value
      send_frame(8'h3C, 32'h12345678, 8'(MAX_PAYLOAD + 1), 1'b0, 1'b0, 0, -1, 1'b0);
      send_frame(8'hC3, 32'h87654321, 8'd255, 1'b0, 1'b0, 0, -1, 1'b0);
   endtask

   task automatic test_check_errors();
      send_frame(8'h42, 32'hCAFEF00D, 8'd5, 1'b1, 1'b0, 0, -1, 1'b0);
      send_frame(8'h24, 32'h0BADCAFE, 8'd4, 1'b0, 1'b1, 0, -1, 1'b0);
      send_frame(8'h99, 32'h55AA55AA, 8'd2, 1'b0, 1'b0, 0, -1, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
   endtask

   task automatic test_frame_timeout();
      write_register(ucfr_pkg::CSR_TIMEOUT_TICKS, 8'd1);
      send_frame(8'h01, 32'h01020304, 8'd3, 1'b0, 1'b0, 1, -1, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
      send_frame(8'h02, 32'h05060708, 8'd3, 1'b0, 1'b0, 2, -1, 1'b0);
      write_register(ucfr_pkg::CSR_TIMEOUT_TICKS, 8'd255);
      // top timeout lets a long silence pass
      send_frame(8'h03, 32'h090A0B0C, 8'd2, 1'b0, 1'b0, 8, -1, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
      write_register(ucfr_pkg::CSR_TIMEOUT_TICKS, ucfr_pkg::TIMEOUT_TICKS_RESET);
   endtask

   task automatic test_hold_and_busy();
      send_frame(8'h77, 32'hA1B2C3D4, 8'd2, 1'b0, 1'b0, 0, -1, 1'b0);
      // held frame drops a new start byte
      send_request(ucfr_pkg::MODE_BYTE, cfg_start, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
      // busy transmitter drops a start byte too
      send_request(ucfr_pkg::MODE_BYTE, cfg_start, 1'b1);
      send_request(MODE_UNUSED, cfg_start, 1'b0);
      send_frame(8'h78, 32'hD4C3B2A1, 8'd1, 1'b0, 1'b0, 0, -1, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
   endtask

   task automatic test_register_extremes();
      write_register(ucfr_pkg::CSR_START_BYTE, 8'h00);
      write_register(ucfr_pkg::CSR_END_BYTE, 8'hFF);
      send_frame(8'hFF, 32'h00FF00FF, 8'd4, 1'b0, 1'b0, 0, -1, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
      send_frame(8'h10, 32'h20304050, 8'd2, 1'b0, 1'b1, 0, -1, 1'b0);
      write_register(ucfr_pkg::CSR_START_BYTE, 8'hFF);
      write_register(ucfr_pkg::CSR_END_BYTE, 8'h00);
      send_frame(8'h00, 32'hFF00FF00, 8'd4, 1'b0, 1'b0, 0, -1, 1'b0);
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
      write_register(ucfr_pkg::CSR_START_BYTE, ucfr_pkg::START_BYTE_RESET);
      write_register(ucfr_pkg::CSR_END_BYTE, ucfr_pkg::END_BYTE_RESET);
   endtask

   task automatic test_output_backpressure();
      send_frame(8'hA5, 32'h01234567, 8'(MAX_PAYLOAD), 1'b0, 1'b0, 0, -1, 1'b0);
      long_hold_cycles = LONG_HOLD;
      send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
   endtask

   task automatic test_random_traffic();
      int round;
      int pick;
      int len;
      int gap;
      int stop_at;
      for (round = 0; round < 4; round++) begin
         if (round == 3) begin
            sender_idling   = 1'b0;
            receiver_idling = 1'b0;
         end
         write_register(ucfr_pkg::CSR_START_BYTE, 8'($urandom_range(0, 255)));
         write_register(ucfr_pkg::CSR_END_BYTE, 8'($urandom_range(0, 255)));
         write_register(ucfr_pkg::CSR_TIMEOUT_TICKS, 8'($urandom_range(1, 6)));
         stop_at = requests_sent + RANDOM_REQUESTS / 4;
         while (requests_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
               pick = $urandom_range(0, 99);
               len = (pick < 80) ? $urandom_range(0, 8) :
                     (pick < 95) ? $urandom_range(9, MAX_PAYLOAD) :
                                   $urandom_range(MAX_PAYLOAD + 1, 255);
               pick = $urandom_range(0, 99);
               gap = (pick < 7)  ? int'(cfg_timeout) + 1 :
                     (pick < 30) ? $urandom_range(1, cfg_timeout) : 0;
               send_frame(8'($urandom_range(0, 255)), $urandom(), 8'(len),
                          $urandom_range(0, 7) == 0, $urandom_range(0, 11) == 0,
                          gap, -1, $urandom_range(0, 9) == 0);
               if ($urandom_range(0, 7) != 0)
                  send_request(ucfr_pkg::MODE_RELEASE, 8'h00, 1'b0);
            end else if (pick < 82) begin
               repeat ($urandom_range(1, 4))
                  send_request(ucfr_pkg::MODE_BYTE, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
            end else if (pick < 90) begin
               send_ticks($urandom_range(1, 3));
            end else if (pick < 97) begin
               send_request(ucfr_pkg::MODE_RELEASE, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            end else begin
               send_request(MODE_UNUSED, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = ucfr_pkg::CSR_START_BYTE;
      csr_wdata = '0;
      reset_decoder();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_default_config();
      test_field_extremes();
      test_check_errors();
      test_frame_timeout();
      test_hold_and_busy();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic();
      wait_for_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // result side stall: random bursts, or one long hold when asked
   initial begin : result_backpressure
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_cycles != 0) begin
            burst = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      ucfr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_items.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: result with none expected: %h", $time, rsp_data);
         end else begin
            want = expected_items.pop_front();
            if (rsp_data.item_kind    !== want.item_kind    ||
                rsp_data.payload_byte !== want.payload_byte ||
                rsp_data.frame_status !== want.frame_status ||
                rsp_data.frame_type   !== want.frame_type   ||
                rsp_data.frame_sign   !== want.frame_sign   ||
                rsp_data.frame_length !== want.frame_length ||
                rsp_data.last_item    !== want.last_item) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"%0t: mismatch kind/byte/status/type/sign/len/last",
                            " expected %0d %h %0d %h %h %h %0d got %0d %h %0d %h %h %h %0d"},
                           $time, want.item_kind, want.payload_byte, want.frame_status,
                           want.frame_type, want.frame_sign, want.frame_length,
                           want.last_item, rsp_data.item_kind, rsp_data.payload_byte,
                           rsp_data.frame_status, rsp_data.frame_type, rsp_data.frame_sign,
                           rsp_data.frame_length, rsp_data.last_item);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
